// ----- rtl/sfcd_pkg.sv -----
// Shared types and constants for the sync-framed command deframer.
`default_nettype none
package sfcd_pkg;

   localparam logic [7:0] SYNC_FIRST   = 8'hAA;
   localparam logic [7:0] SYNC_SECOND  = 8'h55;
   localparam logic [7:0] TYPE_GAMEPAD = 8'h01;
   localparam logic [7:0] TYPE_SERVO   = 8'h03;
   localparam logic [7:0] ANGLE_LIMIT  = 8'd180;

   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned HELD_BYTES = 9;
   localparam int unsigned FIRST_HELD = 2;
   localparam int unsigned STORE_N    = HELD_BYTES - FIRST_HELD;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_GAMEPAD  = 2'd0,
      KIND_SERVO    = 2'd1,
      KIND_CHECKSUM = 2'd2,
      KIND_UNKNOWN  = 2'd3
   } sfcd_kind_type;

   typedef struct packed {
      sfcd_kind_type result_kind;
      logic [7:0]    left_x;
      logic [7:0]    left_y;
      logic [7:0]    right_x;
      logic [7:0]    right_y;
      logic [15:0]   button_bits;
      logic [7:0]    servo_index;
      logic [7:0]    servo_angle;
   } sfcd_result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sfcd_q_status_type;

endpackage
`default_nettype wire

// ----- rtl/sfcd_front.sv -----
// Front end: sync hunt, byte capture, running checksum and frame classification.
`default_nettype none
module sfcd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,
   input  wire sfcd_pkg::sfcd_q_status_type   q_status,
   output logic                               push,
   output sfcd_pkg::sfcd_result_type          push_data
);

   logic [sfcd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [7:0]                   sum_ff, sum_in;
   logic [7:0]                   frame_ff [sfcd_pkg::STORE_N];
   logic                         accept;
   logic                         final_byte;

   assign final_byte = (count_ff >= sfcd_pkg::COUNT_W'(sfcd_pkg::HELD_BYTES));
   assign req_tready = !q_status.full || !final_byte;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && final_byte;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         if (count_ff == '0) begin
            if (req_tdata == sfcd_pkg::SYNC_FIRST) begin
               count_in = sfcd_pkg::COUNT_W'(1);
               sum_in   = req_tdata;
            end
         end else if (count_ff == sfcd_pkg::COUNT_W'(1) &&
                      req_tdata != sfcd_pkg::SYNC_SECOND) begin
            count_in = '0;
            sum_in   = '0;
         end else if (final_byte) begin
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = count_ff + sfcd_pkg::COUNT_W'(1);
            sum_in   = sum_ff + req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // bytes 2..8 of the frame; the sync bytes are never read back
   always_ff @(posedge clock) begin
      for (int i = 0; i < sfcd_pkg::STORE_N; i++) begin
         if (accept && count_ff == sfcd_pkg::COUNT_W'(i + sfcd_pkg::FIRST_HELD)) begin
            frame_ff[i] <= req_tdata;
         end
      end
   end

   always_comb begin
      push_data = '0;
      if (sum_ff != req_tdata) begin
         push_data.result_kind = sfcd_pkg::KIND_CHECKSUM;
      end else if (frame_ff[0] == sfcd_pkg::TYPE_GAMEPAD) begin
         push_data.result_kind = sfcd_pkg::KIND_GAMEPAD;
         push_data.left_x      = frame_ff[1];
         push_data.left_y      = frame_ff[2];
         push_data.right_x     = frame_ff[3];
         push_data.right_y     = frame_ff[4];
         push_data.button_bits = {frame_ff[6], frame_ff[5]};
      end else if (frame_ff[0] == sfcd_pkg::TYPE_SERVO) begin
         push_data.result_kind = sfcd_pkg::KIND_SERVO;
         push_data.servo_index = frame_ff[1];
         push_data.servo_angle = (frame_ff[2] > sfcd_pkg::ANGLE_LIMIT) ?
                                 sfcd_pkg::ANGLE_LIMIT : frame_ff[2];
      end else begin
         push_data.result_kind = sfcd_pkg::KIND_UNKNOWN;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sfcd_queue.sv -----
// Short result queue between the front end and the output stage.
`default_nettype none
module sfcd_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire sfcd_pkg::sfcd_result_type   push_data,
   input  wire logic                        pop,
   output sfcd_pkg::sfcd_result_type        head_data,
   output sfcd_pkg::sfcd_q_status_type      q_status
);

   sfcd_pkg::sfcd_result_type          mem_ff [sfcd_pkg::QUEUE_DEPTH];
   logic [sfcd_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [sfcd_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [sfcd_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign q_status.full  = (count_ff == sfcd_pkg::QCNT_W'(sfcd_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sfcd_pkg::QPTR_W'(sfcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + sfcd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sfcd_pkg::QPTR_W'(sfcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + sfcd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + sfcd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sfcd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sfcd_back.sv -----
// Output stage: registered result transaction fed from the queue.
`default_nettype none
module sfcd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sfcd_pkg::sfcd_q_status_type q_status,
   input  wire sfcd_pkg::sfcd_result_type   head_data,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output sfcd_pkg::sfcd_result_type        rsp_data
);

   logic                      valid_ff, valid_in;
   sfcd_pkg::sfcd_result_type data_ff;

   assign pop        = !q_status.empty && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sync_framed_command_deframer_unit.sv -----
// Top level: sync-framed command deframer with decoupled front end and output stage.
// Accepts one byte per cycle; only the checksum byte stalls, and only with the queue full.
// A result passes through the queue and the output register before it is offered on rsp.
// Non-final bytes yield no transaction; each complete frame yields exactly one.
// Synchronous reset clears the frame counter, checksum, queue and output valid;
// captured frame bytes are not reset.
`default_nettype none
module sync_framed_command_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [7:0] left_x, [15:8] left_y, [23:16] right_x,
                                         // [31:24] right_y, [47:32] button_bits,
                                         // [55:48] servo_index, [63:56] servo_angle
   output logic [1:0]       rsp_tuser    // [1:0] result_kind
);

   sfcd_pkg::sfcd_q_status_type q_status;
   sfcd_pkg::sfcd_result_type   push_data;
   sfcd_pkg::sfcd_result_type   head_data;
   sfcd_pkg::sfcd_result_type   rsp_data;
   logic                        push;
   logic                        pop;

   sfcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   sfcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_status  (q_status)
   );

   sfcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tuser = rsp_data.result_kind;
   assign rsp_tdata = {rsp_data.servo_angle, rsp_data.servo_index, rsp_data.button_bits,
                       rsp_data.right_y, rsp_data.right_x, rsp_data.left_y,
                       rsp_data.left_x};

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("frame pushed into a full queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_status.empty)
      else $error("pushed frame missing from queue");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_tvalid)
      else $error("popped frame not presented");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != sfcd_pkg::KIND_GAMEPAD |-> rsp_tdata[47:0] == 48'd0)
      else $error("stick or button fields set on a non-gamepad result");

   a_angle_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:56] <= sfcd_pkg::ANGLE_LIMIT)
      else $error("servo angle above limit");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for the sync-framed command deframer: framed byte streams, random idling.
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned PHASE_BYTES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [7:0] left_x, [15:8] left_y, [23:16] right_x,
                                     // [31:24] right_y, [47:32] button_bits,
                                     // [55:48] servo_index, [63:56] servo_angle
   logic [1:0]  rsp_tuser;           // [1:0] result_kind

   logic [7:0]                byte_queue[$];
   sfcd_pkg::sfcd_result_type decoded_due[$];

   logic [3:0] held_cnt = '0;
   logic [7:0] frame_buf[sfcd_pkg::HELD_BYTES];
   logic [7:0] chk_sum = '0;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_arm = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_cnt = 0;
   int unsigned err_cnt = 0;
   int unsigned bytes_taken = 0;
   int unsigned kind_seen[4] = '{0, 0, 0, 0};

   sync_framed_command_deframer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Byte-level deframer model; queues one decoded result per complete frame.
   function automatic void deframe_byte(input logic [7:0] b);
      sfcd_pkg::sfcd_result_type r;
      r = '0;
      if (held_cnt == 0 && b != sfcd_pkg::SYNC_FIRST) return;
      if (held_cnt == 1 && b != sfcd_pkg::SYNC_SECOND) begin
         held_cnt = '0;
         chk_sum  = '0;
         return;
      end
      if (held_cnt >= sfcd_pkg::HELD_BYTES) begin
         if (chk_sum != b) begin
            r.result_kind = sfcd_pkg::KIND_CHECKSUM;
         end else if (frame_buf[2] == sfcd_pkg::TYPE_GAMEPAD) begin
            r.result_kind = sfcd_pkg::KIND_GAMEPAD;
            r.left_x      = frame_buf[3];
            r.left_y      = frame_buf[4];
            r.right_x     = frame_buf[5];
            r.right_y     = frame_buf[6];
            r.button_bits = {frame_buf[8], frame_buf[7]};
         end else if (frame_buf[2] == sfcd_pkg::TYPE_SERVO) begin
            r.result_kind = sfcd_pkg::KIND_SERVO;
            r.servo_index = frame_buf[3];
            r.servo_angle = (frame_buf[4] > sfcd_pkg::ANGLE_LIMIT) ?
                            sfcd_pkg::ANGLE_LIMIT : frame_buf[4];
         end else begin
            r.result_kind = sfcd_pkg::KIND_UNKNOWN;
         end
         decoded_due.push_back(r);
         held_cnt = '0;
         chk_sum  = '0;
         return;
      end
      frame_buf[held_cnt] = b;
      chk_sum  = chk_sum + b;
      held_cnt = held_cnt + 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         err_cnt++;
      end
   endfunction

   task automatic push_frame(input logic [7:0] ftype, input logic [7:0] body[6],
                             input bit corrupt);
      logic [7:0] s;
      s = sfcd_pkg::SYNC_FIRST + sfcd_pkg::SYNC_SECOND + ftype;
      byte_queue.push_back(sfcd_pkg::SYNC_FIRST);
      byte_queue.push_back(sfcd_pkg::SYNC_SECOND);
      byte_queue.push_back(ftype);
      foreach (body[i]) begin
         s = s + body[i];
         byte_queue.push_back(body[i]);
      end
      if (corrupt) s = s + 8'($urandom_range(1, 255));
      byte_queue.push_back(s);
   endtask

   task automatic push_random_frame();
      logic [7:0] body[6];
      logic [7:0] ftype;
      int sel;
      sel = $urandom_range(99);
      foreach (body[i]) body[i] = 8'($urandom);
      if (sel < 40) begin
         ftype = sfcd_pkg::TYPE_GAMEPAD;
      end else if (sel < 75) begin
         ftype = sfcd_pkg::TYPE_SERVO;
         if ($urandom_range(1)) body[1] = 8'($urandom_range(170, 255));
      end else begin
         ftype = 8'($urandom);
      end
      push_frame(ftype, body, $urandom_range(99) < 15);
   endtask

   task automatic push_noise();
      int sel;
      int n;
      sel = $urandom_range(2);
      if (sel == 0) begin
         byte_queue.push_back(8'($urandom));
      end else if (sel == 1) begin
         byte_queue.push_back(sfcd_pkg::SYNC_FIRST);
         byte_queue.push_back($urandom_range(1) ? sfcd_pkg::SYNC_FIRST : 8'($urandom));
      end else begin
         // truncated frame: following bytes get absorbed into it
         n = $urandom_range(0, 6);
         byte_queue.push_back(sfcd_pkg::SYNC_FIRST);
         byte_queue.push_back(sfcd_pkg::SYNC_SECOND);
         repeat (n) byte_queue.push_back(8'($urandom));
      end
   endtask

   task automatic fill_random(input int unsigned n_bytes);
      int unsigned start;
      start = byte_queue.size();
      while (byte_queue.size() - start < n_bytes) begin
         if ($urandom_range(99) < 80) push_random_frame();
         else push_noise();
      end
   endtask

   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_tvalid) @(negedge clock);
   endtask

   // Sender: holds an offered byte until its transaction completes.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            bytes_taken++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: each result transaction against the oldest decoded frame.
   always @(posedge clock) begin
      sfcd_pkg::sfcd_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                     $time, rsp_tuser, rsp_tdata);
            err_cnt++;
         end else begin
            want = decoded_due.pop_front();
            check_field("result_kind", 16'(want.result_kind), 16'(rsp_tuser));
            check_field("left_x", 16'(want.left_x), 16'(rsp_tdata[7:0]));
            check_field("left_y", 16'(want.left_y), 16'(rsp_tdata[15:8]));
            check_field("right_x", 16'(want.right_x), 16'(rsp_tdata[23:16]));
            check_field("right_y", 16'(want.right_y), 16'(rsp_tdata[31:24]));
            check_field("button_bits", want.button_bits, rsp_tdata[47:32]);
            check_field("servo_index", 16'(want.servo_index), 16'(rsp_tdata[55:48]));
            check_field("servo_angle", 16'(want.servo_angle), 16'(rsp_tdata[63:56]));
            kind_seen[want.result_kind]++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time, decoded_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [7:0] body[6];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hunting, bad second byte that is itself a sync byte, stray second sync byte
      byte_queue.push_back(8'h00);
      byte_queue.push_back(sfcd_pkg::SYNC_FIRST);
      byte_queue.push_back(sfcd_pkg::SYNC_FIRST);
      byte_queue.push_back(sfcd_pkg::SYNC_SECOND);
      body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      push_frame(sfcd_pkg::TYPE_GAMEPAD, body, 1'b0);
      body = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
      push_frame(sfcd_pkg::TYPE_SERVO, body, 1'b0);
      wait_drained();

      fill_random(PHASE_BYTES);
      wait_drained();

      send_idle_pct = 63;
      fill_random(PHASE_BYTES);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 63;
      fill_random(PHASE_BYTES);
      wait_drained();

      send_idle_pct  = 19;
      recv_stall_pct = 19;
      fill_random(PHASE_BYTES);
      wait_drained();

      // long receiver hold-off while bytes keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_arm       = 1'b1;
      for (int i = 0; i < PHASE_BYTES / 10; i++) push_random_frame();
      wait_drained();

      while (decoded_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Covered %0d bytes in five idling phases plus a %0d-cycle output hold-off.",
               bytes_taken, HOLD_CYCLES);
      $display("Frames: %0d gamepad, %0d servo, %0d checksum error, %0d unknown type.",
               kind_seen[sfcd_pkg::KIND_GAMEPAD], kind_seen[sfcd_pkg::KIND_SERVO],
               kind_seen[sfcd_pkg::KIND_CHECKSUM], kind_seen[sfcd_pkg::KIND_UNKNOWN]);
      if (err_cnt == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sync_framed_command_deframer_unit.f -----
rtl/sfcd_pkg.sv
rtl/sfcd_front.sv
rtl/sfcd_queue.sv
rtl/sfcd_back.sv
rtl/sync_framed_command_deframer_unit.sv
tb/tb_top.sv
